// ===== rtl/rie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_pkg
// Shared constants, opcodes, controller states and control structs for the
// instruction execute unit.
// ----------------------------------------------------------------------------
package rie_pkg;

    localparam int REG_COUNT = 16;
    localparam int MEM_WORDS = 4096;

    localparam int RIDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MIDX_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam bit MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    localparam int XLEN = 32;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_ADDL  = 5'd7,
        OP_SUBL  = 5'd8,
        OP_MOVC  = 5'd9,
        OP_LOAD  = 5'd10,
        OP_STORE = 5'd11,
        OP_LDR   = 5'd12,
        OP_STR   = 5'd13,
        OP_CMP   = 5'd14,
        OP_BZ    = 5'd15,
        OP_BNZ   = 5'd16,
        OP_HALT  = 5'd17
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_D,
        ST_EXEC,
        ST_DIV_WAIT,
        ST_MEM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_en;
        logic load_in;
        logic rd_en;
        logic rdd_en;
        logic ex_en;
        logic div_start;
        logic mem_en;
        logic fin_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic op_div;
        logic op_mem;
        logic op_str;
        logic mem_by_div;
        logic out_free;
    } dp_status_t;

    // Register index reduced modulo REG_COUNT (value below 16, at most 8 steps)
    function automatic logic [RIDX_W-1:0] rf_index(input logic [3:0] field);
        logic [7:0] v;
        v = {4'd0, field};
        for (int k = 0; k < 8; k++)
        begin
            if (v >= 8'(REG_COUNT))
            begin
                v = v - 8'(REG_COUNT);
            end
        end
        return v[RIDX_W-1:0];
    endfunction

endpackage

// ===== rtl/rie_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rie_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rie_pkg::XLEN-1:0]  dividend,
    input  logic [rie_pkg::XLEN-1:0]  divisor,
    output logic                      done,
    output logic [rie_pkg::XLEN-1:0]  quotient
);

    localparam int CNT_W = $clog2(rie_pkg::XLEN);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [rie_pkg::XLEN-1:0] q_reg, q_next;
    logic [rie_pkg::XLEN-1:0] r_reg, r_next;
    logic [rie_pkg::XLEN-1:0] d_reg, d_next;
    logic [rie_pkg::XLEN:0]   shifted;
    logic [rie_pkg::XLEN:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        shifted   = {r_reg, q_reg[rie_pkg::XLEN-1]};
        diff      = shifted - {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[rie_pkg::XLEN])
            begin
                r_next = diff[rie_pkg::XLEN-1:0];
                q_next = {q_reg[rie_pkg::XLEN-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[rie_pkg::XLEN-1:0];
                q_next = {q_reg[rie_pkg::XLEN-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(rie_pkg::XLEN - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == CNT_W'(rie_pkg::XLEN - 1)) |=> done_reg)
        else $error("divider missed done");

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("spurious divider done");

endmodule

// ===== rtl/rie_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_datapath
// Register file, data store, ALU, divider and result register.
// ----------------------------------------------------------------------------
module rie_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rie_pkg::ctrl_cmd_t     cmd,
    output rie_pkg::dp_status_t    status,
    // func[4:0], dest_reg[8:5], src1_reg[12:9], src2_reg[16:13],
    // immediate[32:17], instr_pc[48:33]
    input  logic [55:0]            s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // branch_taken[0], target_pc[16:1], write_value[48:17], zero_now[49],
    // halted[50]
    output logic [55:0]            m_axis_tdata
);

    localparam int XL = rie_pkg::XLEN;
    localparam logic [XL-1:0] MEM_RECIP =
        XL'(64'h1_0000_0000 / 64'(rie_pkg::MEM_WORDS));

    logic [4:0]               func_reg;
    logic [3:0]               dest_reg_q, src1_reg_q, src2_reg_q;
    logic [15:0]              imm_reg, pc_reg;

    logic [XL-1:0]            rf_mem [rie_pkg::REG_COUNT];
    logic [rie_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic [XL-1:0]            dmem [rie_pkg::MEM_WORDS];

    logic [XL-1:0]            a_reg, b_reg, d_reg;
    logic [XL-1:0]            res_reg, addr_reg, load_reg;
    logic                     sign_diff_reg;
    logic                     zero_reg;
    logic [rie_pkg::MIDX_W-1:0] clr_cnt_reg;

    logic                     out_valid_reg;
    logic [55:0]              out_data_reg;

    logic [rie_pkg::RIDX_W-1:0] idx_a, idx_b, idx_d, idx_rd_b;
    logic [XL-1:0]            immx, a_mag, b_mag, addr_sum, res_calc;
    logic [XL-1:0]            div_q, div_dividend, div_divisor;
    logic                     div_done;
    logic [rie_pkg::MIDX_W-1:0] mem_idx;
    logic                     is_store_op;
    logic [XL-1:0]            val;
    logic                     wr_reg, set_z, taken, halt, zero_next;
    logic [XL-1:0]            quot_fixed;

    logic [2*XL-1:0]          red_prod;
    logic [XL-1:0]            red_q_reg, red_r_reg, red_fix;
    logic [1:0]               red_stage_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg   <= s_axis_tdata[4:0];
            dest_reg_q <= s_axis_tdata[8:5];
            src1_reg_q <= s_axis_tdata[12:9];
            src2_reg_q <= s_axis_tdata[16:13];
            imm_reg    <= s_axis_tdata[32:17];
            pc_reg     <= s_axis_tdata[48:33];
        end
    end

    assign idx_a    = rie_pkg::rf_index(src1_reg_q);
    assign idx_b    = rie_pkg::rf_index(src2_reg_q);
    assign idx_d    = rie_pkg::rf_index(dest_reg_q);
    assign idx_rd_b = cmd.rdd_en ? idx_d : idx_b;
    assign immx     = {{16{imm_reg[15]}}, imm_reg};

    // Register file reads, two ports; an unwritten entry reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            a_reg <= rf_valid_reg[idx_a] ? rf_mem[idx_a] : '0;
            b_reg <= rf_valid_reg[idx_rd_b] ? rf_mem[idx_rd_b] : '0;
        end
        if (cmd.rdd_en)
        begin
            d_reg <= rf_valid_reg[idx_rd_b] ? rf_mem[idx_rd_b] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en && wr_reg)
        begin
            rf_mem[idx_d] <= val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (cmd.fin_en && wr_reg)
        begin
            rf_valid_reg[idx_d] <= 1'b1;
        end
    end

    // Execute
    assign a_mag    = a_reg[XL-1] ? (XL'(0) - a_reg) : a_reg;
    assign b_mag    = b_reg[XL-1] ? (XL'(0) - b_reg) : b_reg;
    assign addr_sum = a_reg + (((func_reg == rie_pkg::OP_LOAD) ||
                                (func_reg == rie_pkg::OP_STORE)) ? immx : b_reg);

    always_comb
    begin
        case (rie_pkg::op_t'(func_reg))
            rie_pkg::OP_ADD:  res_calc = a_reg + b_reg;
            rie_pkg::OP_SUB:  res_calc = a_reg - b_reg;
            rie_pkg::OP_MUL:  res_calc = a_reg * b_reg;
            rie_pkg::OP_AND:  res_calc = a_reg & b_reg;
            rie_pkg::OP_OR:   res_calc = a_reg | b_reg;
            rie_pkg::OP_XOR:  res_calc = a_reg ^ b_reg;
            rie_pkg::OP_ADDL: res_calc = a_reg + immx;
            rie_pkg::OP_SUBL: res_calc = a_reg - immx;
            rie_pkg::OP_MOVC: res_calc = immx;
            default:          res_calc = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ex_en)
        begin
            res_reg       <= res_calc;
            addr_reg      <= addr_sum;
            sign_diff_reg <= a_reg[XL-1] ^ b_reg[XL-1];
        end
    end

    // Divider serves DIV only
    assign div_dividend = a_mag;
    assign div_divisor  = b_mag;

    rie_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start && status.op_div),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q)
    );

    // Address reduction for a depth that is not a power of two: reciprocal
    // estimate, back-multiply, then at most one correcting subtract
    assign red_prod = {{XL{1'b0}}, addr_reg} * {{XL{1'b0}}, MEM_RECIP};

    always_ff @(posedge clk)
    begin
        red_q_reg <= red_prod[2*XL-1:XL];
        red_r_reg <= addr_reg - red_q_reg * XL'(rie_pkg::MEM_WORDS);
    end

    assign red_fix = (red_r_reg >= XL'(rie_pkg::MEM_WORDS))
                     ? (red_r_reg - XL'(rie_pkg::MEM_WORDS)) : red_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_stage_reg <= '0;
        end
        else
        begin
            red_stage_reg <= {red_stage_reg[0], cmd.div_start && !status.op_div};
        end
    end

    // Data store: clearing pass after reset, then one access per item
    assign is_store_op = (func_reg == rie_pkg::OP_STORE) || (func_reg == rie_pkg::OP_STR);
    assign mem_idx     = rie_pkg::MEM_POW2 ? addr_reg[rie_pkg::MIDX_W-1:0]
                                           : red_fix[rie_pkg::MIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            dmem[clr_cnt_reg] <= '0;
        end
        else if (cmd.mem_en && is_store_op)
        begin
            dmem[mem_idx] <= (func_reg == rie_pkg::OP_STORE) ? b_reg : d_reg;
        end
        if (cmd.mem_en)
        begin
            load_reg <= dmem[mem_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + rie_pkg::MIDX_W'(1);
        end
    end

    // Retire
    assign quot_fixed = (b_reg == '0) ? '0 : (sign_diff_reg ? (XL'(0) - div_q) : div_q);

    always_comb
    begin
        val    = '0;
        wr_reg = 1'b0;
        set_z  = 1'b0;
        taken  = 1'b0;
        halt   = 1'b0;
        zero_next = zero_reg;
        case (rie_pkg::op_t'(func_reg))
            rie_pkg::OP_ADD, rie_pkg::OP_SUB, rie_pkg::OP_MUL, rie_pkg::OP_AND,
            rie_pkg::OP_OR, rie_pkg::OP_XOR, rie_pkg::OP_MOVC:
            begin
                val = res_reg; wr_reg = 1'b1; set_z = 1'b1;
            end
            rie_pkg::OP_DIV:
            begin
                val = quot_fixed; wr_reg = 1'b1; set_z = 1'b1;
            end
            rie_pkg::OP_ADDL, rie_pkg::OP_SUBL:
            begin
                val = res_reg; wr_reg = 1'b1;
            end
            rie_pkg::OP_LOAD, rie_pkg::OP_LDR:
            begin
                val = load_reg; wr_reg = 1'b1;
            end
            rie_pkg::OP_STORE: val = b_reg;
            rie_pkg::OP_STR:   val = d_reg;
            rie_pkg::OP_CMP:   zero_next = (a_reg == b_reg);
            rie_pkg::OP_BZ:    taken = zero_reg;
            rie_pkg::OP_BNZ:   taken = !zero_reg;
            rie_pkg::OP_HALT:  halt = 1'b1;
            default:           val = '0;
        endcase
        if (set_z)
        begin
            zero_next = (val == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fin_en)
            begin
                zero_reg      <= zero_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en)
        begin
            out_data_reg <= {5'd0, halt, zero_next, val, pc_reg + imm_reg, taken};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign status.clr_done   = (clr_cnt_reg == rie_pkg::MIDX_W'(rie_pkg::MEM_WORDS - 1));
    assign status.div_done   = status.op_div ? div_done : red_stage_reg[1];
    assign status.op_div     = (func_reg == rie_pkg::OP_DIV);
    assign status.op_mem     = (func_reg == rie_pkg::OP_LOAD) || (func_reg == rie_pkg::OP_LDR)
                               || is_store_op;
    assign status.op_str     = (func_reg == rie_pkg::OP_STR);
    assign status.mem_by_div = !rie_pkg::MEM_POW2;
    assign status.out_free   = !out_valid_reg || m_axis_tready;

endmodule

// ===== rtl/rie_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_controller
// Sequencer for one instruction at a time, plus the store clearing pass.
// ----------------------------------------------------------------------------
module rie_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rie_pkg::dp_status_t    status,
    output rie_pkg::ctrl_cmd_t     cmd
);

    rie_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rie_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            rie_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_done)
                begin
                    state_next = rie_pkg::ST_IDLE;
                end
            end
            rie_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = rie_pkg::ST_READ;
                end
            end
            rie_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = status.op_str ? rie_pkg::ST_READ_D : rie_pkg::ST_EXEC;
            end
            rie_pkg::ST_READ_D:
            begin
                cmd.rdd_en = 1'b1;
                state_next = rie_pkg::ST_EXEC;
            end
            rie_pkg::ST_EXEC:
            begin
                cmd.ex_en = 1'b1;
                if (status.op_div || (status.op_mem && status.mem_by_div))
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rie_pkg::ST_DIV_WAIT;
                end
                else if (status.op_mem)
                begin
                    state_next = rie_pkg::ST_MEM;
                end
                else
                begin
                    state_next = rie_pkg::ST_FINISH;
                end
            end
            rie_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = status.op_mem ? rie_pkg::ST_MEM : rie_pkg::ST_FINISH;
                end
            end
            rie_pkg::ST_MEM:
            begin
                cmd.mem_en = 1'b1;
                state_next = rie_pkg::ST_FINISH;
            end
            rie_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.fin_en = 1'b1;
                    state_next = rie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rie_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/risc_instruction_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc_instruction_executor
// Execute unit for a small 32-bit RISC: register file, word data store and
// zero flag, one decoded instruction per request, one result per request.
// ----------------------------------------------------------------------------
// After reset the data store is cleared one word a cycle (MEM_WORDS words,
// 4096 by default) with s_axis_tready low. Instructions are then run one at
// a time by the sequencer: accept, register read, execute, retire for a
// plain ALU, compare or branch instruction; STR adds a third register read,
// LOAD/STORE/LDR/STR a single-port data store access, and DIV a wait while
// the bit-serial divider runs. When MEM_WORDS is not a power of two, address
// reduction by reciprocal multiplication adds a wait on its registers to
// every memory instruction.
// A new request is taken while the previous result still waits on m_axis.
module risc_instruction_executor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[4:0], dest_reg[8:5], src1_reg[12:9], src2_reg[16:13],
    // immediate[32:17], instr_pc[48:33], zero fill above
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // branch_taken[0], target_pc[16:1], write_value[48:17], zero_now[49],
    // halted[50], zero fill above
    output logic [55:0] m_axis_tdata
);

    rie_pkg::ctrl_cmd_t  cmd;
    rie_pkg::dp_status_t status;

    rie_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rie_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
